// ===== rtl/core/amp_pkg.sv =====
`default_nettype none
package amp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ROOT_W           = 24;
    localparam int MID_DEPTH        = 4;
    localparam int MID_PTR_W        = 2;

    localparam logic [15:0] G_RESET   = 16'd256;
    localparam logic [13:0] PITCH_MAX = 14'd11520;

    typedef logic [22:0] t_atan;

    typedef struct packed {
        logic        x_zero;
        logic        x_neg;
        logic [15:0] x_abs;
    } t_xinfo;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        t_xinfo             info;
    } t_sample;

    // atan(2^-i) in degrees, Q.16
    function automatic t_atan atan_q16(input int idx);
        case (idx)
            0:       return 23'd2949120;
            1:       return 23'd1740967;
            2:       return 23'd919879;
            3:       return 23'd466945;
            4:       return 23'd234379;
            5:       return 23'd117304;
            6:       return 23'd58666;
            7:       return 23'd29335;
            8:       return 23'd14668;
            9:       return 23'd7334;
            10:      return 23'd3667;
            11:      return 23'd1833;
            12:      return 23'd917;
            13:      return 23'd458;
            14:      return 23'd229;
            15:      return 23'd115;
            16:      return 23'd57;
            17:      return 23'd29;
            18:      return 23'd14;
            19:      return 23'd7;
            20:      return 23'd4;
            21:      return 23'd2;
            22:      return 23'd1;
            default: return 23'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/accel_magnitude_and_pitch.sv =====
// accelerometer magnitude and pitch
// input side is a queue: drive push with x/y/z counts; an item is taken on
// an edge where push is high and full is low. a four-item buffer sits behind
// the input so the front keeps taking items while the back end is held.
// result side is a queue too: while empty is low the oldest result is on
// o_magnitude_g and o_pitch_deg; pop on an edge with empty low takes it.
// between accept and empty going low, an item passes through the input
// buffer, four multiply/sum stages, 24 square-root stages (one root bit each),
// the CORDIC stages (one rotation each) and the result queue.
// throughput is one item per cycle while pop keeps up.
// when the receiver stalls, the two-entry result queue fills, the back end
// pipeline holds in place, then the input buffer fills and full goes high.
// g_per_lsb is written through i_cfg_we / i_cfg_data; the user must do so
// only while idle, which the block does not enforce. synchronous active-low
// reset empties both queues, drops items in flight, sets g_per_lsb to 256.
`default_nettype none
module accel_magnitude_and_pitch #(
    parameter int CORDIC_STEPS = amp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_x_count,
    input  wire logic signed [15:0] i_y_count,
    input  wire logic signed [15:0] i_z_count,
    output logic                    empty,
    input  wire logic               pop,
    output logic [15:0]             o_magnitude_g,
    output logic signed [14:0]      o_pitch_deg
);
    import amp_pkg::*;

    logic [15:0]        r_g_per_lsb;
    logic               w_mid_valid;
    logic               w_mid_pop;
    t_sample            w_mid_sample;
    logic               w_adv;
    logic               w_b_valid;
    logic [15:0]        w_b_mag;
    logic signed [14:0] w_b_pitch;
    logic               w_oq_push;
    logic               w_oq_pop;

    logic [15:0]        r_oq_mag   [2];
    logic signed [14:0] r_oq_pitch [2];
    logic               r_oq_wr;
    logic               r_oq_rd;
    logic [1:0]         r_oq_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_per_lsb <= G_RESET;
        end else if (i_cfg_we) begin
            r_g_per_lsb <= i_cfg_data;
        end
    end

    amp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_x      (i_x_count),
        .i_y      (i_y_count),
        .i_z      (i_z_count),
        .o_full   (full),
        .i_pop    (w_mid_pop),
        .o_valid  (w_mid_valid),
        .o_sample (w_mid_sample)
    );

    // back end moves only while the result queue has room
    assign w_adv = (r_oq_cnt != 2'd2);

    amp_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (w_mid_valid),
        .i_sample    (w_mid_sample),
        .i_g_per_lsb (r_g_per_lsb),
        .o_pop       (w_mid_pop),
        .o_valid     (w_b_valid),
        .o_mag       (w_b_mag),
        .o_pitch     (w_b_pitch)
    );

    assign w_oq_push     = w_b_valid & w_adv;
    assign w_oq_pop      = pop & ~empty;
    assign empty         = (r_oq_cnt == 2'd0);
    assign o_magnitude_g = r_oq_mag[r_oq_rd];
    assign o_pitch_deg   = r_oq_pitch[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq_mag[r_oq_wr]   <= w_b_mag;
            r_oq_pitch[r_oq_wr] <= w_b_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= 1'b0;
            r_oq_rd  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_oq_push) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (w_oq_pop) begin
                r_oq_rd <= ~r_oq_rd;
            end
            case ({w_oq_push, w_oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 2'd1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 2'd1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

`ifndef SYNTH
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt != 2'd3)
        else $error("result queue count out of range");

    a_oq_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oq_cnt == 2'd1 && w_oq_pop && !w_oq_push) |=> empty)
        else $error("result queue not empty after last item taken");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && !pop) |=> !w_adv)
        else $error("back end moved while result queue full");

    a_mid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> (w_mid_valid && w_adv))
        else $error("buffer read without item or while held");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/amp_front.sv =====
`default_nettype none
module amp_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_z,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output amp_pkg::t_sample        o_sample
);
    import amp_pkg::*;

    t_sample                r_mem [MID_DEPTH];
    logic [MID_PTR_W-1:0]   r_wr;
    logic [MID_PTR_W-1:0]   r_rd;
    logic [MID_PTR_W:0]     r_cnt;
    t_sample                w_cls;
    logic                   w_wr;
    logic                   w_rd;

    // classify the x axis for the pitch path
    always_comb begin
        w_cls.x           = i_x;
        w_cls.y           = i_y;
        w_cls.z           = i_z;
        w_cls.info.x_zero = (i_x == 16'sd0);
        w_cls.info.x_neg  = i_x[15];
        w_cls.info.x_abs  = i_x[15] ? 16'(-i_x) : 16'(i_x);
    end

    assign o_full   = (r_cnt == (MID_PTR_W+1)'(MID_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_sample = r_mem[r_rd];
    assign w_wr     = i_push & ~o_full;
    assign w_rd     = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/amp_isqrt.sv =====
`default_nettype none
module amp_isqrt #(
    parameter int ROOT_BITS = amp_pkg::ROOT_W,
    parameter int SB_W      = 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [2*ROOT_BITS-1:0] i_n,
    input  wire logic [SB_W-1:0]        i_sb,
    output logic                        o_valid,
    output logic [ROOT_BITS-1:0]        o_root,
    output logic [SB_W-1:0]             o_sb
);
    import amp_pkg::*;

    localparam int NW = 2 * ROOT_BITS;
    localparam int RW = ROOT_BITS + 2;

    logic [RW-1:0]        r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS];
    logic [NW-1:0]        r_n    [ROOT_BITS];
    logic [SB_W-1:0]      r_sb   [ROOT_BITS];
    logic                 r_v    [ROOT_BITS];

    // one result bit per stage, restoring method
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic [RW-1:0]        w_rem_p;
        logic [ROOT_BITS-1:0] w_root_p;
        logic [NW-1:0]        w_n_p;
        logic [SB_W-1:0]      w_sb_p;
        logic                 w_v_p;
        logic [RW+1:0]        w_cur;
        logic [RW+1:0]        w_trial;
        logic                 w_ge;

        if (k == 0) begin : g_first
            assign w_rem_p  = '0;
            assign w_root_p = '0;
            assign w_n_p    = i_n;
            assign w_sb_p   = i_sb;
            assign w_v_p    = i_valid;
        end else begin : g_next
            assign w_rem_p  = r_rem[k-1];
            assign w_root_p = r_root[k-1];
            assign w_n_p    = r_n[k-1];
            assign w_sb_p   = r_sb[k-1];
            assign w_v_p    = r_v[k-1];
        end

        assign w_cur   = {w_rem_p, w_n_p[NW-1:NW-2]};
        assign w_trial = {2'b00, w_root_p, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? RW'(w_cur - w_trial) : RW'(w_cur);
                r_root[k] <= {w_root_p[ROOT_BITS-2:0], w_ge};
                r_n[k]    <= {w_n_p[NW-3:0], 2'b00};
                r_sb[k]   <= w_sb_p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_p;
            end
        end
    end

    assign o_valid = r_v[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];
    assign o_sb    = r_sb[ROOT_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/core/amp_cordic.sv =====
`default_nettype none
module amp_cordic #(
    parameter int STEPS = amp_pkg::CORDIC_STEPS_DEF,
    parameter int SB_W  = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [23:0]          i_h,
    input  wire logic [23:0]          i_cy,
    input  wire logic [SB_W-1:0]      i_sb,
    output logic                      o_valid,
    output logic signed [24:0]        o_ang,
    output logic [SB_W-1:0]           o_sb
);
    import amp_pkg::*;

    localparam int CW = 27;
    localparam int AW = 25;

    logic signed [CW-1:0] r_cx  [STEPS];
    logic signed [CW-1:0] r_cy  [STEPS];
    logic signed [AW-1:0] r_ang [STEPS];
    logic [SB_W-1:0]      r_sb  [STEPS];
    logic                 r_v   [STEPS];

    // shift right truncating toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input int s);
        logic [CW-1:0] mag;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        mag = mag >> s;
        return v[CW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic signed [CW-1:0] w_cx_p;
        logic signed [CW-1:0] w_cy_p;
        logic signed [AW-1:0] w_ang_p;
        logic [SB_W-1:0]      w_sb_p;
        logic                 w_v_p;
        logic signed [CW-1:0] w_dx;
        logic signed [CW-1:0] w_dy;
        logic signed [AW-1:0] w_step;

        if (k == 0) begin : g_first
            assign w_cx_p  = $signed({3'b000, i_h});
            assign w_cy_p  = $signed({3'b000, i_cy});
            assign w_ang_p = '0;
            assign w_sb_p  = i_sb;
            assign w_v_p   = i_valid;
        end else begin : g_next
            assign w_cx_p  = r_cx[k-1];
            assign w_cy_p  = r_cy[k-1];
            assign w_ang_p = r_ang[k-1];
            assign w_sb_p  = r_sb[k-1];
            assign w_v_p   = r_v[k-1];
        end

        assign w_dx   = shr_tz(w_cy_p, k);
        assign w_dy   = shr_tz(w_cx_p, k);
        assign w_step = $signed({2'b00, atan_q16(k)});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cy_p > 0) begin
                    r_cx[k]  <= w_cx_p + w_dx;
                    r_cy[k]  <= w_cy_p - w_dy;
                    r_ang[k] <= w_ang_p + w_step;
                end else begin
                    r_cx[k]  <= w_cx_p - w_dx;
                    r_cy[k]  <= w_cy_p + w_dy;
                    r_ang[k] <= w_ang_p - w_step;
                end
                r_sb[k] <= w_sb_p;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_p;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_ang   = r_ang[STEPS-1];
    assign o_sb    = r_sb[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/amp_back.sv =====
`default_nettype none
module amp_back #(
    parameter int CORDIC_STEPS = amp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire amp_pkg::t_sample   i_sample,
    input  wire logic [15:0]        i_g_per_lsb,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic [15:0]             o_mag,
    output logic signed [14:0]      o_pitch
);
    import amp_pkg::*;

    logic               r1_v, r2_v, r3_v, r4_v;
    logic [30:0]        r1_x2, r1_y2, r1_z2;
    t_xinfo             r1_info, r2_info, r3_info, r4_info;
    logic [31:0]        r2_s, r2_yz, r3_yz, r4_yz;
    logic [47:0]        r3_sg;
    logic [47:0]        r4_p;
    logic               r4_sat;

    logic signed [31:0] w_x2, w_y2, w_z2;
    logic [63:0]        w_p;

    logic               w_va, w_vb;
    logic [ROOT_W-1:0]  w_root_m, w_root_h;
    logic [17:0]        w_sb_a;
    logic               w_sb_b;
    logic [15:0]        w_mag;

    logic               w_vc;
    logic signed [24:0] w_ang;
    logic [17:0]        w_sb_c;
    logic [24:0]        w_rnd;
    logic [15:0]        w_q7;
    logic [13:0]        w_lim;

    assign w_x2 = i_sample.x * i_sample.x;
    assign w_y2 = i_sample.y * i_sample.y;
    assign w_z2 = i_sample.z * i_sample.z;
    assign w_p  = 64'(r3_sg) * 64'(i_g_per_lsb);

    assign o_pop = i_adv & i_valid;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_x2   <= w_x2[30:0];
            r1_y2   <= w_y2[30:0];
            r1_z2   <= w_z2[30:0];
            r1_info <= i_sample.info;
            r2_s    <= 32'(r1_x2) + 32'(r1_y2) + 32'(r1_z2);
            r2_yz   <= 32'(r1_y2) + 32'(r1_z2);
            r2_info <= r1_info;
            r3_sg   <= 48'(r2_s) * 48'(i_g_per_lsb);
            r3_yz   <= r2_yz;
            r3_info <= r2_info;
            // anything at or above 2^48 gives a root past full scale
            r4_sat  <= |w_p[63:48];
            r4_p    <= w_p[47:0];
            r4_yz   <= r3_yz;
            r4_info <= r3_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    amp_isqrt #(
        .ROOT_BITS (ROOT_W),
        .SB_W      (18)
    ) u_isqrt_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_adv),
        .i_valid (r4_v),
        .i_n     (r4_p),
        .i_sb    ({r4_sat, r4_info.x_neg, r4_info.x_abs}),
        .o_valid (w_va),
        .o_root  (w_root_m),
        .o_sb    (w_sb_a)
    );

    amp_isqrt #(
        .ROOT_BITS (ROOT_W),
        .SB_W      (1)
    ) u_isqrt_yz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_adv),
        .i_valid (r4_v),
        .i_n     ({r4_yz, 16'h0000}),
        .i_sb    (r4_info.x_zero),
        .o_valid (w_vb),
        .o_root  (w_root_h),
        .o_sb    (w_sb_b)
    );

    assign w_mag = w_sb_a[17] ? 16'hFFFF : w_root_m[23:8];

    amp_cordic #(
        .STEPS (CORDIC_STEPS),
        .SB_W  (18)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_adv),
        .i_valid (w_va & w_vb),
        .i_h     (w_root_h),
        .i_cy    ({w_sb_a[15:0], 8'h00}),
        .i_sb    ({w_mag, w_sb_b, w_sb_a[16]}),
        .o_valid (w_vc),
        .o_ang   (w_ang),
        .o_sb    (w_sb_c)
    );

    // clamp to 0..90, round to Q.7, then apply the sign of x (zero when x is zero)
    always_comb begin
        w_rnd = w_ang[24] ? 25'd0 : (25'(w_ang) + 25'd256);
        w_q7  = w_rnd[24:9];
        w_lim = (w_q7 > 16'(PITCH_MAX)) ? PITCH_MAX : w_q7[13:0];
        if (w_sb_c[1]) begin
            o_pitch = 15'sd0;
        end else if (w_sb_c[0]) begin
            o_pitch = -$signed({1'b0, w_lim});
        end else begin
            o_pitch = $signed({1'b0, w_lim});
        end
    end

    assign o_valid = w_vc;
    assign o_mag   = w_sb_c[17:2];

endmodule
`default_nettype wire

// ===== tb/tb_amp_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_amp_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic signed [15:0] i_x_count,
    input  wire logic signed [15:0] i_y_count,
    input  wire logic signed [15:0] i_z_count,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic [15:0]        i_magnitude_g,
    input  wire logic signed [14:0] i_pitch_deg,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [15:0]        mag;
        logic signed [14:0] pitch;
    } t_reading;

    t_reading    reading_q[$];
    logic [15:0] scale_g;

    function automatic longint unsigned int_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint shift_toward_zero(input longint v, input int s);
        if (v < 0) return -(longint'((-v) >>> s));
        return v >>> s;
    endfunction

    function automatic logic signed [14:0] tilt_angle(input longint x, input longint y,
                                                      input longint z);
        longint cx, cy, ang, dx, dy, m;
        if (x == 0) return '0;
        cx = longint'(int_root(longint'(y * y + z * z) << 16));
        cy = (x < 0 ? -x : x) * 256;
        ang = 0;
        for (int i = 0; i < amp_pkg::CORDIC_STEPS_DEF && i < amp_pkg::ATAN_ENTRIES; i++) begin
            dx = shift_toward_zero(cy, i);
            dy = shift_toward_zero(cx, i);
            if (cy > 0) begin
                cx += dx; cy -= dy; ang += longint'(amp_pkg::atan_q16(i));
            end else begin
                cx -= dx; cy += dy; ang -= longint'(amp_pkg::atan_q16(i));
            end
        end
        if (ang < 0) ang = 0;
        m = (ang + 256) >>> 9;
        if (m > 11520) m = 11520;
        return x < 0 ? 15'(-m) : 15'(m);
    endfunction

    function automatic t_reading predict_reading(input logic signed [15:0] xs,
                                                 input logic signed [15:0] ys,
                                                 input logic signed [15:0] zs,
                                                 input logic [15:0] g);
        t_reading r;
        longint x, y, z;
        longint unsigned s, m;
        x = xs; y = ys; z = zs;
        s = longint'(x * x + y * y + z * z);
        m = int_root(s * g * g) >> 8;
        if (m > 65535) m = 65535;
        r.mag = m[15:0];
        r.pitch = tilt_angle(x, y, z);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_reading want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            scale_g <= amp_pkg::G_RESET;
            reading_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) scale_g <= i_cfg_data;
            if (i_push && !i_full)
                reading_q.push_back(predict_reading(i_x_count, i_y_count, i_z_count, scale_g));
            if (i_pop && !i_empty) begin
                if (reading_q.size() == 0) begin
                    $error("unexpected result mag=%0d pitch=%0d", i_magnitude_g, i_pitch_deg);
                    errs = errs + 1;
                end else begin
                    want = reading_q.pop_front();
                    if (want.mag !== i_magnitude_g) begin
                        $error("magnitude_g expected %0d actual %0d", want.mag, i_magnitude_g);
                        errs = errs + 1;
                    end
                    if (want.pitch !== i_pitch_deg) begin
                        $error("pitch_deg expected %0d actual %0d", want.pitch, i_pitch_deg);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

    assign o_pending = reading_q.size();

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] x_cnt = '0, y_cnt = '0, z_cnt = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [15:0]        mag_g;
    logic signed [14:0] pitch;
    int                 fail_count;
    int                 pending;
    bit                 hold_results = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    accel_magnitude_and_pitch dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .push(push), .full(full), .i_x_count(x_cnt), .i_y_count(y_cnt),
        .i_z_count(z_cnt), .empty(empty), .pop(pop), .o_magnitude_g(mag_g),
        .o_pitch_deg(pitch)
    );

    tb_amp_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_push(push), .i_full(full), .i_x_count(x_cnt), .i_y_count(y_cnt),
        .i_z_count(z_cnt), .i_empty(empty), .i_pop(pop), .i_magnitude_g(mag_g),
        .i_pitch_deg(pitch), .o_fail_count(fail_count), .o_pending(pending)
    );

    // optional random gap, then offer one item and wait for acceptance
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        x_cnt <= x; y_cnt <= y; z_cnt <= z;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] g);
        cfg_we <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random pops, with one long hold-off on request
    always @(posedge clk) begin
        int wait_n;
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_results) begin
            pop <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge clk);
            hold_results = 1'b0;
        end else if (pop && !empty) begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (wait_n > 0) begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            pop <= 1'b1;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        logic [15:0] scales [6];
        scales = '{16'd1, 16'd65535, 16'd256, 16'd0, 16'd4096, 16'd300};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, zero axes, zero y and z
        send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h7fff, 16'h8000, 1'b0);
        send_sample(16'h7fff, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'h8000, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'hffff, 16'h0000, 16'h0000, 1'b0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_sample(16'h0001, 16'h7fff, 16'h7fff, 1'b0);
        send_sample(16'h0100, 16'h0100, 16'h0000, 1'b0);
        send_sample(16'hff00, 16'h0000, 16'h0100, 1'b0);
        send_sample(16'h5555, 16'haaaa, 16'h5555, 1'b0);
        send_sample(16'haaaa, 16'h5555, 16'haaaa, 1'b0);
        // sender pause until everything is back
        drain_and_settle();
        foreach (scales[k]) begin
            write_scale(scales[k]);
            if (k == 0) hold_results = 1'b1;
            for (int n = 0; n < 275; n++)
                send_sample(pick_count(), pick_count(), pick_count(),
                            (n % 60) < 12);
            drain_and_settle();
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
